>>> src/jlu_pkg.sv
`default_nettype none

package jlu_pkg;

  // code point and hex escape widths
  localparam int unsigned CpWidth  = 21;
  localparam int unsigned HexWidth = 16;

  typedef logic [CpWidth-1:0]  cp_t;
  typedef logic [HexWidth-1:0] hex_acc_t;

  // lexer modes
  typedef enum logic [3:0] {
    M_BETWEEN    = 4'd0,
    M_SLASH      = 4'd1,
    M_BLOCK      = 4'd2,
    M_BLOCK_STAR = 4'd3,
    M_LINE       = 4'd4,
    M_STRING     = 4'd5,
    M_ESCAPE     = 4'd6,
    M_HEX        = 4'd7,
    M_LITERAL    = 4'd8,
    M_SINK       = 4'd9
  } mode_e;

  // token kinds on the result channel
  typedef enum logic [2:0] {
    TK_PUNCT     = 3'd0,
    TK_STR_START = 3'd1,
    TK_STR_CHAR  = 3'd2,
    TK_STR_END   = 3'd3,
    TK_LIT_CHAR  = 3'd4,
    TK_LIT_END   = 3'd5,
    TK_ERROR     = 3'd6,
    TK_DOC_END   = 3'd7
  } tok_kind_e;

  typedef struct packed {
    mode_e      mode;
    logic       quote_kind;
    logic [1:0] hex_count;
    hex_acc_t   hex_accum;
    logic       doc_start;
    logic       after_equals;
  } lex_state_t;

  localparam lex_state_t StateReset = '{
    mode:         M_BETWEEN,
    quote_kind:   1'b0,
    hex_count:    2'd0,
    hex_accum:    '0,
    doc_start:    1'b1,
    after_equals: 1'b0
  };

  typedef struct packed {
    tok_kind_e kind;
    cp_t       value;
  } token_t;

  // tokens caused by one character, at most three
  localparam int unsigned MaxTokens = 3;

  typedef struct packed {
    logic [1:0]               count;
    token_t [MaxTokens-1:0]   tok;
  } res_batch_t;

endpackage

`default_nettype wire

>>> src/jlu_in_if.sv
`default_nettype none

interface jlu_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        doc_end;

  modport source (output valid, output code_point, output doc_end, input ready);
  modport sink   (input valid, input code_point, input doc_end, output ready);
endinterface

`default_nettype wire

>>> src/jlu_out_if.sv
`default_nettype none

interface jlu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [20:0] token_value;
  logic        run_last;

  modport source (output valid, output token_kind, output token_value, output run_last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_value, input run_last,
                  output ready);
endinterface

`default_nettype wire

>>> src/jlu_step.sv
`default_nettype none

module jlu_step import jlu_pkg::*; (
  input  lex_state_t st_i,
  input  cp_t        cp_i,
  input  logic       last_i,
  output lex_state_t st_o,
  output res_batch_t res_o
);

  // characters of interest
  localparam cp_t ChTab    = 21'h00009;
  localparam cp_t ChBs     = 21'h00008;
  localparam cp_t ChLf     = 21'h0000A;
  localparam cp_t ChFf     = 21'h0000C;
  localparam cp_t ChCr     = 21'h0000D;
  localparam cp_t ChSpace  = 21'h00020;
  localparam cp_t ChDquote = 21'h00022;
  localparam cp_t ChHash   = 21'h00023;
  localparam cp_t ChSquote = 21'h00027;
  localparam cp_t ChStar   = 21'h0002A;
  localparam cp_t ChComma  = 21'h0002C;
  localparam cp_t ChSlash  = 21'h0002F;
  localparam cp_t ChColon  = 21'h0003A;
  localparam cp_t ChSemi   = 21'h0003B;
  localparam cp_t ChEquals = 21'h0003D;
  localparam cp_t ChGt     = 21'h0003E;
  localparam cp_t ChLbrack = 21'h0005B;
  localparam cp_t ChBslash = 21'h0005C;
  localparam cp_t ChRbrack = 21'h0005D;
  localparam cp_t ChLbrace = 21'h0007B;
  localparam cp_t ChRbrace = 21'h0007D;
  localparam cp_t ChLowB   = 21'h00062;
  localparam cp_t ChLowF   = 21'h00066;
  localparam cp_t ChLowN   = 21'h0006E;
  localparam cp_t ChLowR   = 21'h00072;
  localparam cp_t ChLowT   = 21'h00074;
  localparam cp_t ChLowU   = 21'h00075;
  localparam cp_t ChBom    = 21'h0FEFF;

  // error numbers
  localparam cp_t ErrComment = 21'd0;
  localparam cp_t ErrEscape  = 21'd1;
  localparam cp_t ErrString  = 21'd2;
  localparam cp_t ErrHex     = 21'd3;

  typedef struct packed {
    logic   emit;
    token_t tok;
    mode_e  mode;
    logic   quote_we;
    logic   quote;
    logic   ae;
  } btw_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  function automatic logic is_ws(cp_t c);
    return c == ChTab || c == ChSpace || c == ChLf || c == ChCr;
  endfunction

  function automatic logic is_punct(cp_t c);
    return c == ChLbrace || c == ChRbrace || c == ChLbrack || c == ChRbrack ||
           c == ChColon || c == ChComma || c == ChSemi || c == ChBslash ||
           c == ChFf || c == ChEquals;
  endfunction

  function automatic logic is_sep(cp_t c);
    return is_punct(c) || c == ChSlash || c == ChHash || is_ws(c);
  endfunction

  function automatic cp_t unescape(cp_t c);
    cp_t r;
    r = c;
    if (c == ChLowT) r = ChTab;
    if (c == ChLowB) r = ChBs;
    if (c == ChLowN) r = ChLf;
    if (c == ChLowR) r = ChCr;
    if (c == ChLowF) r = ChFf;
    return r;
  endfunction

  // digit values: '0'..'9' keep the low nibble, letters add nine
  function automatic hex_dig_t hex_digit(cp_t c);
    hex_dig_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= 21'h30 && c <= 21'h39) begin
      h.ok = 1'b1;
    end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  // character seen between tokens
  function automatic btw_t between_f(cp_t c);
    btw_t b;
    b.emit     = 1'b0;
    b.tok.kind = TK_PUNCT;
    b.tok.value = c;
    b.mode     = M_BETWEEN;
    b.quote_we = 1'b0;
    b.quote    = 1'b0;
    b.ae       = 1'b0;
    priority if (is_ws(c)) begin
    end else if (c == ChSlash) begin
      b.mode = M_SLASH;
    end else if (c == ChHash) begin
      b.mode = M_LINE;
    end else if (c == ChDquote || c == ChSquote) begin
      b.emit     = 1'b1;
      b.tok.kind = TK_STR_START;
      b.quote_we = 1'b1;
      b.quote    = (c == ChSquote);
      b.mode     = M_STRING;
    end else if (is_punct(c)) begin
      b.emit = 1'b1;
      b.ae   = (c == ChEquals);
    end else begin
      b.emit     = 1'b1;
      b.tok.kind = TK_LIT_CHAR;
      b.mode     = M_LITERAL;
    end
    return b;
  endfunction

  // one character through the lexer
  always_comb begin
    lex_state_t s;
    btw_t       b;
    hex_dig_t   h;
    hex_acc_t   acc;
    logic [1:0] n;
    token_t [MaxTokens-1:0] toks;
    logic       active;
    logic       use_b;

    s = st_i;
    s.doc_start    = 1'b0;
    s.after_equals = 1'b0;
    n      = 2'd0;
    toks   = '0;
    b      = between_f(cp_i);
    h      = hex_digit(cp_i);
    acc    = {st_i.hex_accum[HexWidth-5:0], h.val};
    active = (st_i.mode <= M_LITERAL);
    use_b  = 1'b0;

    if (!active) begin
      if (last_i) s = StateReset;
    end else begin
      if (st_i.doc_start && cp_i == ChBom) begin
      end else if (st_i.after_equals && cp_i == ChGt && st_i.mode == M_BETWEEN) begin
      end else begin
        unique case (st_i.mode)
          M_BETWEEN: use_b = 1'b1;
          M_SLASH: begin
            if (cp_i == ChStar) begin
              s.mode = M_BLOCK;
            end else if (cp_i == ChSlash) begin
              s.mode = M_LINE;
            end else begin
              toks[n] = '{kind: TK_PUNCT, value: ChSlash};
              n = n + 2'd1;
              use_b = 1'b1;
            end
          end
          M_BLOCK: begin
            if (cp_i == ChStar) s.mode = M_BLOCK_STAR;
          end
          M_BLOCK_STAR: begin
            if (cp_i == ChSlash) s.mode = M_BETWEEN;
            else if (cp_i != ChStar) s.mode = M_BLOCK;
          end
          M_LINE: begin
            if (cp_i == ChCr || cp_i == ChLf) s.mode = M_BETWEEN;
          end
          M_STRING: begin
            if (cp_i == (st_i.quote_kind ? ChSquote : ChDquote)) begin
              toks[n] = '{kind: TK_STR_END, value: cp_i};
              n = n + 2'd1;
              s.mode = M_BETWEEN;
            end else if (cp_i == ChBslash) begin
              s.mode = M_ESCAPE;
            end else begin
              toks[n] = '{kind: TK_STR_CHAR, value: cp_i};
              n = n + 2'd1;
            end
          end
          M_ESCAPE: begin
            if (cp_i == ChLowU) begin
              s.hex_count = 2'd0;
              s.hex_accum = '0;
              s.mode      = M_HEX;
            end else begin
              toks[n] = '{kind: TK_STR_CHAR, value: unescape(cp_i)};
              n = n + 2'd1;
              s.mode = M_STRING;
            end
          end
          M_HEX: begin
            if (!h.ok) begin
              toks[n] = '{kind: TK_ERROR, value: ErrHex};
              n = n + 2'd1;
              s.mode = M_SINK;
            end else if (st_i.hex_count == 2'd3) begin
              toks[n] = '{kind: TK_STR_CHAR, value: {{(CpWidth-HexWidth){1'b0}}, acc}};
              n = n + 2'd1;
              s.hex_count = 2'd0;
              s.hex_accum = '0;
              s.mode      = M_STRING;
            end else begin
              s.hex_accum = acc;
              s.hex_count = st_i.hex_count + 2'd1;
            end
          end
          M_LITERAL: begin
            if (is_sep(cp_i)) begin
              toks[n] = '{kind: TK_LIT_END, value: '0};
              n = n + 2'd1;
              use_b = 1'b1;
            end else begin
              toks[n] = '{kind: TK_LIT_CHAR, value: cp_i};
              n = n + 2'd1;
            end
          end
          default: begin
          end
        endcase

        // separator or fresh character handled between tokens
        if (use_b) begin
          s.mode = b.mode;
          if (b.emit) begin
            toks[n] = b.tok;
            n = n + 2'd1;
          end
          if (b.quote_we) s.quote_kind = b.quote;
          if (b.ae) s.after_equals = 1'b1;
        end
      end

      // close the document
      if (last_i) begin
        unique case (s.mode)
          M_BLOCK, M_BLOCK_STAR: begin
            toks[n] = '{kind: TK_ERROR, value: ErrComment};
            n = n + 2'd1;
          end
          M_ESCAPE, M_HEX: begin
            toks[n] = '{kind: TK_ERROR, value: ErrEscape};
            n = n + 2'd1;
          end
          M_STRING: begin
            toks[n] = '{kind: TK_ERROR, value: ErrString};
            n = n + 2'd1;
          end
          M_SLASH: begin
            toks[n] = '{kind: TK_PUNCT, value: ChSlash};
            n = n + 2'd1;
            toks[n] = '{kind: TK_DOC_END, value: '0};
            n = n + 2'd1;
          end
          M_SINK: begin
          end
          default: begin
            toks[n] = '{kind: TK_DOC_END, value: '0};
            n = n + 2'd1;
          end
        endcase
        s = StateReset;
      end
    end

    st_o       = s;
    res_o.count = n;
    res_o.tok   = toks;
  end

endmodule

`default_nettype wire

>>> src/json_lexer_unescape_core.sv
`default_nettype none

// Streaming JSON lexer: one Unicode code point per input transaction (doc_end marks the last
// character of a document), tokens out on the result channel with run_last on the final token
// caused by each character. An accepted character is held in the input register, is lexed
// there and its tokens (zero to three) land in a three-entry result queue that drains one token a
// cycle while out_o.ready is high. Plain text streams at one character per cycle while the
// receiver keeps ready high; a character that yields several tokens keeps the queue busy until
// they drain, and the next character that yields tokens waits in the input register until the
// last of them leaves. Characters that yield no token (whitespace, comments, anything after an
// error) never wait on the output side. After doc_end the lexer is back in its reset state.
module json_lexer_unescape_core import jlu_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  jlu_in_if.sink     in_i,
  jlu_out_if.source  out_o
);

  // input register
  logic       in_vld_q;
  cp_t        in_cp_q;
  logic       in_last_q;

  // lexer state
  lex_state_t st_q;
  lex_state_t st_d;
  res_batch_t res;

  // result queue
  token_t [MaxTokens-1:0] q_tok_q;
  logic   [MaxTokens-1:0] q_last_q;
  logic   [1:0]           q_cnt_q;

  logic pop;
  logic can_load;
  logic fire;

  jlu_step u_step (
    .st_i   (st_q),
    .cp_i   (in_cp_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // handshake control
  assign pop      = (q_cnt_q != 2'd0) && out_o.ready;
  assign can_load = (q_cnt_q == 2'd0) || ((q_cnt_q == 2'd1) && pop);
  assign fire     = in_vld_q && ((res.count == 2'd0) || can_load);
  assign in_i.ready = !in_vld_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_cp_q   <= in_i.code_point;
      in_last_q <= in_i.doc_end;
    end
  end

  // lexer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // result queue count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= 2'd0;
    end else if (fire && res.count != 2'd0) begin
      q_cnt_q <= res.count;
    end else if (pop) begin
      q_cnt_q <= q_cnt_q - 2'd1;
    end
  end

  // result queue payload: load a batch or shift toward the head
  always_ff @(posedge clk_i) begin
    if (fire && res.count != 2'd0) begin
      q_tok_q     <= res.tok;
      q_last_q[0] <= (res.count == 2'd1);
      q_last_q[1] <= (res.count == 2'd2);
      q_last_q[2] <= (res.count == 2'd3);
    end else if (pop) begin
      q_tok_q[0]  <= q_tok_q[1];
      q_tok_q[1]  <= q_tok_q[2];
      q_last_q[0] <= q_last_q[1];
      q_last_q[1] <= q_last_q[2];
    end
  end

  // output side
  assign out_o.valid       = (q_cnt_q != 2'd0);
  assign out_o.token_kind  = q_tok_q[0].kind;
  assign out_o.token_value = q_tok_q[0].value;
  assign out_o.run_last    = q_last_q[0];

  // a single queued token closes its character's run
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd1) |-> q_last_q[0])
    else $error("lone queued token without run_last");

  // a token without run_last always has a successor queued
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q != 2'd0 && !q_last_q[0]) |-> (q_cnt_q == 2'd2 || q_cnt_q == 2'd3))
    else $error("run cut short in result queue");

  // a batch never overwrites undelivered tokens
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.count != 2'd0) |-> (q_cnt_q == 2'd0 || (q_cnt_q == 2'd1 && out_o.ready)))
    else $error("result batch loaded over pending tokens");

  // end of document returns the lexer to its reset state
  a_doc_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_last_q) |=> (st_q == StateReset))
    else $error("lexer state not reset after document end");

  // partial hex escape only inside a hex escape or after its failure
  a_hex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.hex_count != 2'd0) |-> (st_q.mode == M_HEX || st_q.mode == M_SINK))
    else $error("hex digit count outside hex escape");

endmodule

`default_nettype wire

>>> bench/json_lexer_unescape_core_tb.sv
`timescale 1ns / 100ps

module json_lexer_unescape_core_tb;
  import jlu_pkg::*;

  // character codes the lexer reacts to
  localparam cp_t ChBksp    = 21'h08;
  localparam cp_t ChTab     = 21'h09;
  localparam cp_t ChLf      = 21'h0A;
  localparam cp_t ChFf      = 21'h0C;
  localparam cp_t ChCr      = 21'h0D;
  localparam cp_t ChSpace   = 21'h20;
  localparam cp_t ChDquote  = 21'h22;
  localparam cp_t ChHash    = 21'h23;
  localparam cp_t ChSquote  = 21'h27;
  localparam cp_t ChStar    = 21'h2A;
  localparam cp_t ChComma   = 21'h2C;
  localparam cp_t ChSlash   = 21'h2F;
  localparam cp_t ChDigit0  = 21'h30;
  localparam cp_t ChDigit9  = 21'h39;
  localparam cp_t ChColon   = 21'h3A;
  localparam cp_t ChSemi    = 21'h3B;
  localparam cp_t ChEq      = 21'h3D;
  localparam cp_t ChGt      = 21'h3E;
  localparam cp_t ChUpperA  = 21'h41;
  localparam cp_t ChUpperF  = 21'h46;
  localparam cp_t ChLBrack  = 21'h5B;
  localparam cp_t ChBslash  = 21'h5C;
  localparam cp_t ChRBrack  = 21'h5D;
  localparam cp_t ChLowerA  = 21'h61;
  localparam cp_t ChLowerF  = 21'h66;
  localparam cp_t ChLowerG  = 21'h67;
  localparam cp_t ChLBrace  = 21'h7B;
  localparam cp_t ChRBrace  = 21'h7D;
  localparam cp_t EscB      = 21'h62;
  localparam cp_t EscF      = 21'h66;
  localparam cp_t EscN      = 21'h6E;
  localparam cp_t EscR      = 21'h72;
  localparam cp_t EscT      = 21'h74;
  localparam cp_t EscU      = 21'h75;
  localparam cp_t ChBom     = 21'hFEFF;
  localparam cp_t CpMax     = 21'h1FFFFF;

  // error numbers carried in token_value
  localparam cp_t ErrComment = 21'd0;
  localparam cp_t ErrEscape  = 21'd1;
  localparam cp_t ErrString  = 21'd2;
  localparam cp_t ErrHex     = 21'd3;

  localparam int RandomChars  = 250;
  localparam int RxHoldCycles = 80;
  localparam int DrainCycles  = 20;

  typedef struct packed {
    tok_kind_e kind;
    cp_t       value;
    logic      last;
  } lex_tok_t;

  typedef struct packed {
    cp_t        cp;
    logic       last;
    logic       typed;
    logic [1:0] n;
    tok_kind_e  k0;
    cp_t        v0;
    tok_kind_e  k1;
    cp_t        v1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jlu_in_if  in_ch ();
  jlu_out_if out_ch ();

  json_lexer_unescape_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lexer state as predicted
  mode_e      lx_mode;
  logic       lx_single_quote;
  logic [1:0] lx_hex_cnt;
  hex_acc_t   lx_hex_acc;
  logic       lx_doc_first;
  logic       lx_after_eq;

  lex_tok_t step_toks[$];
  lex_tok_t tokens_due[$];
  cp_t      doc_buf[$];
  logic     doc_broken;
  logic     hold_off_req = 1'b0;

  int mismatches     = 0;
  int tokens_checked = 0;
  int errors_checked = 0;
  int chars_lexed    = 0;
  int docs_sent      = 0;
  int holds_done     = 0;
  int drain_pauses   = 0;
  int burst_left     = 8;

  // directed stimulus, typed rows carry their expected tokens
  stim_row_t dir_rows [26] = '{
    '{ChBom,    1'b0, 1'b1, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChLBrace, 1'b0, 1'b1, 2'd1, TK_PUNCT,    ChLBrace, TK_PUNCT,   '0},
    '{ChDquote, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChBslash, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{EscU,     1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChUpperF, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChLowerA, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChDigit0, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChDigit9, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChDquote, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChEq,     1'b0, 1'b1, 2'd1, TK_PUNCT,    ChEq,     TK_PUNCT,   '0},
    '{ChGt,     1'b0, 1'b1, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{CpMax,    1'b0, 1'b1, 2'd1, TK_LIT_CHAR, CpMax,    TK_PUNCT,   '0},
    '{'0,       1'b1, 1'b1, 2'd2, TK_LIT_CHAR, '0,       TK_DOC_END, '0},
    '{ChSquote, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChBslash, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{EscU,     1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChLowerG, 1'b0, 1'b1, 2'd1, TK_ERROR,    ErrHex,   TK_PUNCT,   '0},
    '{ChRBrace, 1'b1, 1'b1, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChSlash,  1'b1, 1'b1, 2'd2, TK_PUNCT,    ChSlash,  TK_DOC_END, '0},
    '{ChSlash,  1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChStar,   1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChDquote, 1'b1, 1'b1, 2'd1, TK_ERROR,    ErrComment, TK_PUNCT, '0},
    '{ChDquote, 1'b0, 1'b0, 2'd0, TK_PUNCT,    '0,       TK_PUNCT,   '0},
    '{ChBslash, 1'b1, 1'b1, 2'd1, TK_ERROR,    ErrEscape, TK_PUNCT,  '0},
    '{ChDquote, 1'b1, 1'b1, 2'd2, TK_STR_START, ChDquote, TK_ERROR, ErrString}
  };

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ns: token %0d: %s", $time, tokens_checked, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void lexer_clear();
    lx_mode         = M_BETWEEN;
    lx_single_quote = 1'b0;
    lx_hex_cnt      = '0;
    lx_hex_acc      = '0;
    lx_doc_first    = 1'b1;
    lx_after_eq     = 1'b0;
  endfunction

  // at most three tokens per character
  function automatic void put_tok(tok_kind_e kind, cp_t value);
    if (step_toks.size() < MaxTokens) step_toks.push_back('{kind, value, 1'b0});
  endfunction

  function automatic bit is_ws(cp_t c);
    return c == ChTab || c == ChSpace || c == ChLf || c == ChCr;
  endfunction

  function automatic bit is_punct(cp_t c);
    return c == ChLBrace || c == ChRBrace || c == ChLBrack || c == ChRBrack ||
           c == ChColon || c == ChComma || c == ChSemi || c == ChBslash ||
           c == ChFf || c == ChEq;
  endfunction

  function automatic bit is_sep(cp_t c);
    return is_punct(c) || is_ws(c) || c == ChSlash || c == ChHash;
  endfunction

  function automatic int hex_digit(cp_t c);
    if (c >= ChDigit0 && c <= ChDigit9) return int'(c - ChDigit0);
    if (c >= ChUpperA && c <= ChUpperF) return int'(c - ChUpperA) + 10;
    if (c >= ChLowerA && c <= ChLowerF) return int'(c - ChLowerA) + 10;
    return -1;
  endfunction

  function automatic cp_t unescape_char(cp_t c);
    case (c)
      EscT:    return ChTab;
      EscB:    return ChBksp;
      EscN:    return ChLf;
      EscR:    return ChCr;
      EscF:    return ChFf;
      default: return c;
    endcase
  endfunction

  // character seen between tokens
  function automatic void between_tokens(cp_t c);
    if (is_ws(c)) return;
    if (c == ChSlash) begin
      lx_mode = M_SLASH;
    end else if (c == ChHash) begin
      lx_mode = M_LINE;
    end else if (c == ChDquote || c == ChSquote) begin
      put_tok(TK_STR_START, c);
      lx_single_quote = (c == ChSquote);
      lx_mode = M_STRING;
    end else if (is_punct(c)) begin
      put_tok(TK_PUNCT, c);
      if (c == ChEq) lx_after_eq = 1'b1;
    end else begin
      put_tok(TK_LIT_CHAR, c);
      lx_mode = M_LITERAL;
    end
  endfunction

  // predicts the tokens of one character into step_toks
  function automatic void lex_char(cp_t c, logic last);
    logic     first;
    logic     eq_before;
    int       d;
    lex_tok_t tail;
    first        = lx_doc_first;
    eq_before    = lx_after_eq;
    lx_doc_first = 1'b0;
    lx_after_eq  = 1'b0;
    step_toks.delete();

    // after an error everything up to the document end is swallowed
    if (lx_mode > M_LITERAL) begin
      if (last) lexer_clear();
      return;
    end

    if (first && c == ChBom) begin
      // byte order mark at document start is dropped
    end else if (eq_before && c == ChGt && lx_mode == M_BETWEEN) begin
      // arrow after equals is dropped
    end else begin
      case (lx_mode)
        M_BETWEEN: between_tokens(c);
        M_SLASH: begin
          if (c == ChStar) begin
            lx_mode = M_BLOCK;
          end else if (c == ChSlash) begin
            lx_mode = M_LINE;
          end else begin
            put_tok(TK_PUNCT, ChSlash);
            lx_mode = M_BETWEEN;
            between_tokens(c);
          end
        end
        M_BLOCK: begin
          if (c == ChStar) lx_mode = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (c == ChSlash) lx_mode = M_BETWEEN;
          else if (c != ChStar) lx_mode = M_BLOCK;
        end
        M_LINE: begin
          if (c == ChCr || c == ChLf) lx_mode = M_BETWEEN;
        end
        M_STRING: begin
          if (c == (lx_single_quote ? ChSquote : ChDquote)) begin
            put_tok(TK_STR_END, c);
            lx_mode = M_BETWEEN;
          end else if (c == ChBslash) begin
            lx_mode = M_ESCAPE;
          end else begin
            put_tok(TK_STR_CHAR, c);
          end
        end
        M_ESCAPE: begin
          if (c == EscU) begin
            lx_hex_cnt = '0;
            lx_hex_acc = '0;
            lx_mode    = M_HEX;
          end else begin
            put_tok(TK_STR_CHAR, unescape_char(c));
            lx_mode = M_STRING;
          end
        end
        M_HEX: begin
          d = hex_digit(c);
          if (d < 0) begin
            put_tok(TK_ERROR, ErrHex);
            lx_mode = M_SINK;
          end else begin
            lx_hex_acc = {lx_hex_acc[HexWidth-5:0], d[3:0]};
            if (lx_hex_cnt == 2'd3) begin
              put_tok(TK_STR_CHAR, cp_t'(lx_hex_acc));
              lx_hex_cnt = '0;
              lx_hex_acc = '0;
              lx_mode    = M_STRING;
            end else begin
              lx_hex_cnt = lx_hex_cnt + 2'd1;
            end
          end
        end
        M_LITERAL: begin
          if (is_sep(c)) begin
            put_tok(TK_LIT_END, '0);
            lx_mode = M_BETWEEN;
            between_tokens(c);
          end else begin
            put_tok(TK_LIT_CHAR, c);
          end
        end
        default: ;
      endcase
    end

    // document end closes whatever is open
    if (last) begin
      case (lx_mode)
        M_BLOCK, M_BLOCK_STAR: put_tok(TK_ERROR, ErrComment);
        M_ESCAPE, M_HEX:       put_tok(TK_ERROR, ErrEscape);
        M_STRING:              put_tok(TK_ERROR, ErrString);
        M_SLASH: begin
          put_tok(TK_PUNCT, ChSlash);
          put_tok(TK_DOC_END, '0);
        end
        M_SINK: ;
        default: put_tok(TK_DOC_END, '0);
      endcase
      lexer_clear();
    end

    if (step_toks.size() > 0) begin
      tail = step_toks.pop_back();
      tail.last = 1'b1;
      step_toks.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- document generator

  function automatic cp_t rand_text_char();
    case ($urandom_range(0, 3))
      0:       return cp_t'($urandom_range(32'h20, 32'h7E));
      1:       return cp_t'($urandom_range(32'h80, 32'hFFFF));
      2:       return cp_t'($urandom_range(0, CpMax));
      default: return cp_t'($urandom_range(32'h41, 32'h5A));
    endcase
  endfunction

  function automatic cp_t rand_hex_digit();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return ChDigit0 + cp_t'(v);
    if (v < 16) return ChUpperA + cp_t'(v - 10);
    return ChLowerA + cp_t'(v - 16);
  endfunction

  function automatic cp_t rand_ws();
    case ($urandom_range(0, 3))
      0:       return ChTab;
      1:       return ChLf;
      2:       return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  function automatic void add_punct();
    case ($urandom_range(0, 9))
      0:       doc_buf.push_back(ChLBrace);
      1:       doc_buf.push_back(ChRBrace);
      2:       doc_buf.push_back(ChLBrack);
      3:       doc_buf.push_back(ChRBrack);
      4:       doc_buf.push_back(ChColon);
      5:       doc_buf.push_back(ChComma);
      6:       doc_buf.push_back(ChSemi);
      7:       doc_buf.push_back(ChBslash);
      8:       doc_buf.push_back(ChFf);
      default: doc_buf.push_back(ChEq);
    endcase
  endfunction

  // quoted string with plain characters and escapes
  function automatic void add_string();
    cp_t q;
    q = $urandom_range(0, 1) ? ChSquote : ChDquote;
    doc_buf.push_back(q);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: begin
          doc_buf.push_back(ChBslash);
          case ($urandom_range(0, 8))
            0:       doc_buf.push_back(EscT);
            1:       doc_buf.push_back(EscB);
            2:       doc_buf.push_back(EscN);
            3:       doc_buf.push_back(EscR);
            4:       doc_buf.push_back(EscF);
            5:       doc_buf.push_back(ChDquote);
            6:       doc_buf.push_back(ChSquote);
            7:       doc_buf.push_back(ChBslash);
            default: doc_buf.push_back(rand_text_char());
          endcase
        end
        1: begin
          doc_buf.push_back(ChBslash);
          doc_buf.push_back(EscU);
          repeat (4) begin
            if (doc_broken && $urandom_range(0, 5) == 0) doc_buf.push_back(rand_text_char());
            else doc_buf.push_back(rand_hex_digit());
          end
        end
        default: doc_buf.push_back(rand_text_char());
      endcase
    end
    doc_buf.push_back(q);
  endfunction

  function automatic void add_comment();
    case ($urandom_range(0, 2))
      0: begin
        doc_buf.push_back(ChSlash);
        doc_buf.push_back(ChStar);
        repeat ($urandom_range(0, 5))
          doc_buf.push_back($urandom_range(0, 3) == 0 ? ChStar : rand_text_char());
        doc_buf.push_back(ChStar);
        doc_buf.push_back(ChSlash);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          doc_buf.push_back(ChSlash);
          doc_buf.push_back(ChSlash);
        end else begin
          doc_buf.push_back(ChHash);
        end
        repeat ($urandom_range(0, 5)) doc_buf.push_back(rand_text_char());
        doc_buf.push_back($urandom_range(0, 1) ? ChCr : ChLf);
      end
    endcase
  endfunction

  // one document: mostly well formed, some cut short, some pure noise
  function automatic void gen_doc();
    int cut;
    doc_buf.delete();
    doc_broken = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) == 0) doc_buf.push_back(ChBom);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16))
        doc_buf.push_back($urandom_range(0, 2) == 0 ? cp_t'($urandom_range(0, CpMax)) :
                                                      cp_t'($urandom_range(0, 127)));
      return;
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1: add_punct();
        2, 3: add_string();
        4, 5: begin
          doc_buf.push_back(rand_text_char());
          repeat ($urandom_range(0, 5)) doc_buf.push_back(rand_text_char());
        end
        6: repeat ($urandom_range(1, 3)) doc_buf.push_back(rand_ws());
        7: add_comment();
        8: doc_buf.push_back(ChSlash);
        default: begin
          doc_buf.push_back(ChEq);
          doc_buf.push_back(ChGt);
        end
      endcase
    end
    if (doc_broken && doc_buf.size() > 1) begin
      cut = $urandom_range(1, doc_buf.size());
      while (doc_buf.size() > cut) void'(doc_buf.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------- sender

  // offers one character, waits for the transaction, then paces the burst
  task automatic send_char(cp_t c, logic last, logic use_model);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.code_point <= c;
    in_ch.doc_end    <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (lx_mode != M_SINK) chars_lexed++;
    lex_char(c, last);
    if (use_model) foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  endtask

  // sender goes quiet until every expected token is back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    drain_pauses++;
  endtask

  initial begin : stimulus
    int start_chars;
    in_ch.valid      = 1'b0;
    in_ch.code_point = '0;
    in_ch.doc_end    = 1'b0;
    lexer_clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        if (dir_rows[i].n > 0)
          tokens_due.push_back('{dir_rows[i].k0, dir_rows[i].v0, dir_rows[i].n == 2'd1});
        if (dir_rows[i].n > 1)
          tokens_due.push_back('{dir_rows[i].k1, dir_rows[i].v1, 1'b1});
      end
      send_char(dir_rows[i].cp, dir_rows[i].last, !dir_rows[i].typed);
    end
    wait_drained();

    // random documents
    start_chars = chars_lexed;
    while (chars_lexed - start_chars < RandomChars) begin
      gen_doc();
      if (docs_sent == 3) hold_off_req = 1'b1;
      for (int k = 0; k < doc_buf.size(); k++)
        send_char(doc_buf[k], k == doc_buf.size() - 1, 1'b1);
      docs_sent++;
      if (docs_sent % 6 == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("lexed %0d characters (%0d random documents), checked %0d tokens, %0d of them errors",
             chars_lexed, docs_sent, tokens_checked, errors_checked);
    $display("receiver hold-offs %0d, sender drain pauses %0d", holds_done, drain_pauses);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // ready pattern in segments, plus one long hold-off on request
  initial begin : rx_pace
    int seg_left;
    int seg_style;
    out_ch.ready = 1'b0;
    seg_left  = 0;
    seg_style = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk);
        hold_off_req = 1'b0;
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          seg_left  = $urandom_range(8, 40);
          seg_style = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= seg_left[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- token check

  always @(posedge clk) begin : token_check
    lex_tok_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tokens_checked++;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("kind %0d value 0x%0h arrived with nothing expected",
                                  out_ch.token_kind, out_ch.token_value));
      end else begin
        want = tokens_due.pop_front();
        if (want.kind == TK_ERROR) errors_checked++;
        if (out_ch.token_kind != want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_ch.token_kind, want.kind));
        if (out_ch.token_value != want.value)
          report_mismatch($sformatf("value 0x%0h, expected 0x%0h",
                                    out_ch.token_value, want.value));
        if (out_ch.run_last != want.last)
          report_mismatch($sformatf("run_last %0b, expected %0b", out_ch.run_last, want.last));
      end
    end
  end

  // run limit
  initial begin : watchdog
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
